// File: src/assert_macros.svh
// assertion macros shared by the vector unit modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication: consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/v3au_pkg.sv
// types, codes and helpers for the three-component vector unit
// no dependencies
package v3au_pkg;

   localparam int DIMS = 3;
   localparam int VecLanes = (DIMS > 3) ? 3 : ((DIMS < 1) ? 1 : DIMS);
   localparam int QueueDepth = 4;

   localparam logic [2:0] ACT_ADD = 3'd0;
   localparam logic [2:0] ACT_DOT = 3'd1;
   localparam logic [2:0] ACT_LEN2 = 3'd2;
   localparam logic [2:0] ACT_LEN = 3'd3;
   localparam logic [2:0] ACT_SCALE = 3'd4;
   localparam logic [2:0] ACT_DIV = 3'd5;
   localparam logic [2:0] ACT_NORM = 3'd6;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SMIN = 32'sh8000_0000;

   typedef struct packed {
      logic [2:0] action;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] scalar_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic signed [31:0] r_scalar;
      logic [1:0] status;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic [2:0] action;
      logic lane_div;
      logic zero_div;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] scalar_in;
   } item_type;

   function automatic logic signed [31:0] sat_w(input logic signed [65:0] v,
                                                output logic ov);
      logic signed [31:0] r;
      ov = 1'b0;
      r = v[31:0];
      if (v > 66'sd2147483647) begin
         ov = 1'b1;
         r = SMAX;
      end else if (v < -66'sd2147483648) begin
         ov = 1'b1;
         r = SMIN;
      end
      return r;
   endfunction

endpackage

// File: src/v3au_front.sv
// front end: accepts requests, classifies them, feeds the item queue
// depends on v3au_pkg
module v3au_front
   import v3au_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input req_type req_data,
   input logic q_full,
   output logic busy,
   output logic push,
   output item_type item
);

   always_comb begin
      busy = q_full;
      push = start && !q_full;
      item.action = req_data.action;
      item.lane_div = (req_data.action == ACT_DIV) || (req_data.action == ACT_NORM);
      item.zero_div = (req_data.scalar_in == 32'sd0);
      item.a_x = req_data.a_x;
      item.a_y = (VecLanes > 1) ? req_data.a_y : 32'sd0;
      item.a_z = (VecLanes > 2) ? req_data.a_z : 32'sd0;
      item.b_x = req_data.b_x;
      item.b_y = (VecLanes > 1) ? req_data.b_y : 32'sd0;
      item.b_z = (VecLanes > 2) ? req_data.b_z : 32'sd0;
      item.scalar_in = req_data.scalar_in;
   end

`include "assert_macros.svh"
   `ASSERT_CLK(a_no_push_full, clock, reset, !(push && q_full), "push into full queue")
   `ASSERT_CLK(a_busy_full, clock, reset, busy == q_full, "busy mismatch")

endmodule

// File: src/v3au_queue.sv
// short item queue between front and back ends
// depends on v3au_pkg
module v3au_queue
   import v3au_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic push,
   input item_type push_item,
   input logic pop,
   output logic full,
   output logic empty,
   output item_type head
);

   localparam int PtrW = $clog2(QueueDepth);

   item_type mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ff, rd_ff;
   logic [PtrW:0] cnt_ff;

   assign full = (cnt_ff == (PtrW+1)'(QueueDepth));
   assign empty = (cnt_ff == '0);
   assign head = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
      end
   end

`include "assert_macros.svh"
   `ASSERT_CLK(a_no_underflow, clock, reset, !(pop && empty), "pop from empty queue")
   `ASSERT_CLK(a_cnt_range, clock, reset, cnt_ff <= (PtrW+1)'(QueueDepth), "count too large")

endmodule

// File: src/v3au_div.sv
// shared radix-2 divider: 64-bit dividend by 64-bit divisor, one bit per cycle
// depends on v3au_pkg
module v3au_div
   import v3au_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic go,
   input logic signed [63:0] dividend,
   input logic signed [63:0] divisor,
   output logic done,
   output logic signed [63:0] quot
);

   typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_DONE} dv_state_type;

   dv_state_type st_ff;
   logic [63:0] num_ff;
   logic [63:0] den_ff;
   logic [64:0] rem_ff;
   logic neg_ff;
   logic [6:0] cnt_ff;
   logic [64:0] trial;

   assign trial = {rem_ff[63:0], num_ff[63]} - {1'b0, den_ff};
   assign done = (st_ff == DV_DONE);
   assign quot = neg_ff ? -$signed(num_ff) : $signed(num_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= DV_IDLE;
         cnt_ff <= '0;
      end else begin
         case (st_ff)
            DV_IDLE: begin
               if (go) begin
                  st_ff <= DV_RUN;
                  cnt_ff <= 7'd64;
                  num_ff <= dividend[63] ? 64'(-dividend) : 64'(dividend);
                  den_ff <= divisor[63] ? 64'(-divisor) : 64'(divisor);
                  neg_ff <= dividend[63] ^ divisor[63];
                  rem_ff <= '0;
               end
            end
            DV_RUN: begin
               if (!trial[64]) begin
                  rem_ff <= trial;
                  num_ff <= {num_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[63:0], num_ff[63]};
                  num_ff <= {num_ff[62:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == 7'd1) st_ff <= DV_DONE;
            end
            DV_DONE: st_ff <= DV_IDLE;
            default: st_ff <= DV_IDLE;
         endcase
      end
   end

`include "assert_macros.svh"
   `ASSERT_NEXT(a_done_pulse, clock, reset, done, !done, "done held")

endmodule

// File: src/v3au_back.sv
// back end: executes items from the queue, root and division run iteratively
// depends on v3au_pkg, v3au_div
module v3au_back
   import v3au_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic q_empty,
   input item_type head,
   output logic pop,
   output logic rsp_valid,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {BK_IDLE, BK_MUL, BK_SUM, BK_SQRT, BK_DIV, BK_OUT}
      bk_state_type;

   bk_state_type st_ff;
   bk_state_type idle_next;
   item_type it_ff;
   logic signed [63:0] p_ff [3];
   logic [65:0] ss_ff;
   logic [65:0] sq_n_ff;
   logic [63:0] sq_r_ff;
   logic [5:0] sq_cnt_ff;
   logic [1:0] lane_ff;
   logic signed [31:0] r_ff [3];
   logic ov_ff;
   rsp_type out_ff;
   rsp_type out_in;
   logic out_v_ff;
   logic signed [63:0] div_num, div_den, div_q;
   logic div_go, div_done;
   logic [65:0] sq_trial;
   logic [65:0] sq_rem_sh;
   logic [63:0] sq_root_nx;
   logic signed [31:0] lane_a;
   logic signed [31:0] lane_b;
   logic signed [63:0] pr;
   logic signed [65:0] dsum;
   logic sat_o;
   logic signed [31:0] sat_v;
   logic ov_x, ov_y, ov_z, ov_s;

   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;
   assign pop = (st_ff == BK_IDLE) && !q_empty;

   // restoring square root on the 66-bit sum of squares
   assign sq_rem_sh = {sq_n_ff[63:0], ss_ff[65:64]};
   assign sq_trial = sq_rem_sh - {sq_r_ff, 2'b01};
   assign sq_root_nx = !sq_trial[65] ? {sq_r_ff[62:0], 1'b1} : {sq_r_ff[62:0], 1'b0};

   always_comb begin
      case (lane_ff)
         2'd0: begin lane_a = it_ff.a_x; lane_b = it_ff.b_x; end
         2'd1: begin lane_a = it_ff.a_y; lane_b = it_ff.b_y; end
         default: begin lane_a = it_ff.a_z; lane_b = it_ff.b_z; end
      endcase
      // one 32x32 product per cycle
      case (it_ff.action)
         ACT_DOT: pr = 64'(lane_a) * 64'(lane_b);
         ACT_SCALE: pr = 64'(lane_a) * 64'(it_ff.scalar_in);
         default: pr = 64'(lane_a) * 64'(lane_a);
      endcase
      dsum = 66'(p_ff[0]) + 66'(p_ff[1]) + 66'(p_ff[2]);
      div_num = 64'(lane_a) <<< 16;
      div_den = (it_ff.action == ACT_DIV) ? 64'(it_ff.scalar_in) : $signed(sq_r_ff);
      div_go = (st_ff == BK_DIV) && !div_done;
      // lane result: quotient while dividing, shifted product while scaling
      sat_v = sat_w((st_ff == BK_DIV) ? 66'(div_q) : 66'(pr >>> 16), sat_o);

      case (head.action)
         ACT_ADD: idle_next = BK_OUT;
         ACT_DIV: idle_next = head.zero_div ? BK_OUT : BK_DIV;
         ACT_DOT, ACT_LEN2, ACT_LEN, ACT_SCALE, ACT_NORM: idle_next = BK_MUL;
         default: idle_next = BK_OUT;
      endcase

      ov_x = 1'b0;
      ov_y = 1'b0;
      ov_z = 1'b0;
      ov_s = 1'b0;
      out_in = '0;
      out_in.status = ST_OK;
      case (it_ff.action)
         ACT_ADD: begin
            out_in.r_x = sat_w(66'(it_ff.a_x) + 66'(it_ff.b_x), ov_x);
            out_in.r_y = sat_w(66'(it_ff.a_y) + 66'(it_ff.b_y), ov_y);
            out_in.r_z = sat_w(66'(it_ff.a_z) + 66'(it_ff.b_z), ov_z);
            if (ov_x || ov_y || ov_z) out_in.status = ST_SAT;
         end
         ACT_DOT: begin
            out_in.r_scalar = sat_w($signed(ss_ff) >>> 16, ov_s);
            if (ov_s) out_in.status = ST_SAT;
         end
         ACT_LEN2: begin
            if (ss_ff[65:47] != '0) begin
               out_in.r_scalar = SMAX;
               out_in.status = ST_SAT;
            end else begin
               out_in.r_scalar = ss_ff[47:16];
            end
         end
         ACT_LEN: begin
            if (sq_r_ff[63:31] != '0) begin
               out_in.r_scalar = SMAX;
               out_in.status = ST_SAT;
            end else begin
               out_in.r_scalar = sq_r_ff[31:0];
            end
         end
         ACT_SCALE, ACT_DIV, ACT_NORM: begin
            out_in.r_x = r_ff[0];
            out_in.r_y = r_ff[1];
            out_in.r_z = r_ff[2];
            if ((it_ff.action == ACT_DIV && it_ff.zero_div) ||
                (it_ff.action == ACT_NORM && sq_r_ff == 64'd0))
               out_in.status = ST_ZERO;
            else if (ov_ff) out_in.status = ST_SAT;
         end
         default: ;
      endcase
   end

   v3au_div u_div (
      .clock(clock), .reset(reset), .go(div_go), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quot(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
         out_v_ff <= 1'b0;
         lane_ff <= '0;
      end else begin
         out_v_ff <= (st_ff == BK_OUT);
         case (st_ff)
            BK_IDLE: begin
               if (!q_empty) begin
                  it_ff <= head;
                  lane_ff <= '0;
                  ov_ff <= 1'b0;
                  for (int i = 0; i < 3; i++) begin
                     p_ff[i] <= '0;
                     r_ff[i] <= '0;
                  end
                  st_ff <= idle_next;
               end
            end
            BK_MUL: begin
               p_ff[lane_ff] <= pr;
               if (it_ff.action == ACT_SCALE) begin
                  r_ff[lane_ff] <= sat_v;
                  if (sat_o) ov_ff <= 1'b1;
               end
               if (lane_ff == 2'(VecLanes - 1)) begin
                  lane_ff <= '0;
                  st_ff <= (it_ff.action == ACT_SCALE) ? BK_OUT : BK_SUM;
               end else begin
                  lane_ff <= lane_ff + 1'b1;
               end
            end
            BK_SUM: begin
               ss_ff <= dsum;
               sq_n_ff <= '0;
               sq_r_ff <= '0;
               sq_cnt_ff <= 6'd33;
               st_ff <= (it_ff.action == ACT_DOT || it_ff.action == ACT_LEN2) ?
                        BK_OUT : BK_SQRT;
            end
            BK_SQRT: begin
               sq_n_ff <= !sq_trial[65] ? sq_trial : sq_rem_sh;
               sq_r_ff <= sq_root_nx;
               ss_ff <= {ss_ff[63:0], 2'b00};
               sq_cnt_ff <= sq_cnt_ff - 1'b1;
               if (sq_cnt_ff == 6'd1) begin
                  st_ff <= (it_ff.action == ACT_NORM && sq_root_nx != 64'd0) ?
                           BK_DIV : BK_OUT;
               end
            end
            BK_DIV: begin
               if (div_done) begin
                  r_ff[lane_ff] <= sat_v;
                  if (sat_o) ov_ff <= 1'b1;
                  if (lane_ff == 2'(VecLanes - 1)) st_ff <= BK_OUT;
                  else lane_ff <= lane_ff + 1'b1;
               end
            end
            BK_OUT: begin
               out_ff <= out_in;
               st_ff <= BK_IDLE;
            end
            default: st_ff <= BK_IDLE;
         endcase
      end
   end

`include "assert_macros.svh"
   `ASSERT_NEXT(a_out_pulse, clock, reset, out_v_ff, !out_v_ff, "result held two cycles")
   `ASSERT_NEXT(a_pop_leaves_idle, clock, reset, pop, st_ff != BK_IDLE, "pop without start")

endmodule

// File: src/vector3_arithmetic_unit_core.sv
// requests are taken one per cycle into a 4-entry queue until it fills; the back
// end takes one item at a time
// synchronous active-high reset empties the queue and idles the back end
// results are strobed for one cycle on rsp_valid; the receiver cannot stall
module vector3_arithmetic_unit_core
   import v3au_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data
);

   logic q_push;
   logic q_pop;
   logic q_full;
   logic q_empty;
   item_type fr_item, q_head;

   v3au_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .q_full(q_full), .busy(busy), .push(q_push), .item(fr_item)
   );

   v3au_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_item(fr_item),
      .pop(q_pop), .full(q_full), .empty(q_empty), .head(q_head)
   );

   v3au_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .head(q_head),
      .pop(q_pop), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

endmodule

// File: tb/v3au_checker.sv
// checker for the three-component vector unit: watches requests and results,
// predicts each result and compares it field by field
// depends on v3au_pkg
module v3au_checker
   import v3au_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input req_type req_data,
   input logic rsp_valid,
   input rsp_type rsp_data,
   output int fail_count,
   output int pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type expected_rsps[$];

   function automatic logic signed [127:0] floor_shift16(input logic signed [127:0] p);
      return p >>> 16;
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                  inout logic ov);
      if (v > 128'sd2147483647) begin
         ov = 1'b1;
         return SMAX;
      end
      if (v < -128'sd2147483648) begin
         ov = 1'b1;
         return SMIN;
      end
      return v[31:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic rsp_type predict_vector_op(input req_type rq);
      rsp_type r;
      logic signed [127:0] a[3];
      logic signed [127:0] b[3];
      logic signed [127:0] s;
      logic signed [127:0] acc;
      logic signed [31:0] rv[3];
      logic [63:0] sumsq;
      logic [63:0] len;
      logic ov;
      logic zero;
      a[0] = rq.a_x; a[1] = rq.a_y; a[2] = rq.a_z;
      b[0] = rq.b_x; b[1] = rq.b_y; b[2] = rq.b_z;
      s = rq.scalar_in;
      ov = 1'b0;
      zero = 1'b0;
      for (int i = 0; i < 3; i++) rv[i] = 0;
      r = '0;
      sumsq = 0;
      for (int i = 0; i < VecLanes; i++) sumsq = sumsq + 64'(a[i] * a[i]);
      len = floor_sqrt(sumsq);
      case (rq.action)
         ACT_ADD: for (int i = 0; i < VecLanes; i++) rv[i] = clamp32(a[i] + b[i], ov);
         ACT_DOT: begin
            acc = 0;
            for (int i = 0; i < VecLanes; i++) acc = acc + a[i] * b[i];
            r.r_scalar = clamp32(floor_shift16(acc), ov);
         end
         ACT_LEN2: begin
            // sum of squares wraps at 64 bits like an unsigned accumulator
            r.r_scalar = clamp32($signed({64'd0, sumsq >> 16}), ov);
         end
         ACT_LEN: r.r_scalar = clamp32($signed({64'd0, len}), ov);
         ACT_SCALE:
            for (int i = 0; i < VecLanes; i++) rv[i] = clamp32(floor_shift16(a[i] * s), ov);
         ACT_DIV: begin
            if (s == 0) zero = 1'b1;
            else for (int i = 0; i < VecLanes; i++) rv[i] = clamp32((a[i] * 65536) / s, ov);
         end
         ACT_NORM: begin
            if (len == 0) zero = 1'b1;
            else for (int i = 0; i < VecLanes; i++)
               rv[i] = clamp32((a[i] * 65536) / $signed({64'd0, len}), ov);
         end
         default: ;
      endcase
      r.r_x = rv[0]; r.r_y = rv[1]; r.r_z = rv[2];
      r.status = zero ? ST_ZERO : (ov ? ST_SAT : ST_OK);
      return r;
   endfunction

   initial fail_count = 0;
   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) expected_rsps.push_back(predict_vector_op(req_data));
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t unexpected result %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (want.r_x !== rsp_data.r_x || want.r_y !== rsp_data.r_y ||
                   want.r_z !== rsp_data.r_z || want.r_scalar !== rsp_data.r_scalar ||
                   want.status !== rsp_data.status) begin
                  $display("%0t mismatch expected x=%h y=%h z=%h s=%h st=%0d", $time,
                           want.r_x, want.r_y, want.r_z, want.r_scalar, want.status);
                  $display("%0t          actual   x=%h y=%h z=%h s=%h st=%0d", $time,
                           rsp_data.r_x, rsp_data.r_y, rsp_data.r_z, rsp_data.r_scalar,
                           rsp_data.status);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

// File: tb/vector3_arithmetic_unit_core_tb.sv
// stimulus and verdict for the three-component vector unit
// depends on v3au_pkg, vector3_arithmetic_unit_core and v3au_checker
module vector3_arithmetic_unit_core_tb;
   import v3au_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   int fail_count;
   int pending_count;
   int idle_cycles;

   vector3_arithmetic_unit_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   v3au_checker result_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: long stretch with no request or result taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_component();
      case ($urandom_range(0, 7))
         0: return SMAX;
         1: return SMIN;
         2: return 0;
         3: return $signed($urandom_range(0, 131072)) - 65536;
         4: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
         default: return $urandom;
      endcase
   endfunction

   // start drops at a falling edge only when a gap follows; a request stays
   // on the port until accepted
   task automatic send_request(input req_type rq, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= rq;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic send_random(input int gap);
      req_type rq;
      rq.action = 3'($urandom_range(0, 7));
      rq.a_x = pick_component(); rq.a_y = pick_component(); rq.a_z = pick_component();
      rq.b_x = pick_component(); rq.b_y = pick_component(); rq.b_z = pick_component();
      rq.scalar_in = ($urandom_range(0, 9) == 0) ? 32'sd0 : pick_component();
      send_request(rq, gap);
   endtask

   initial begin
      req_type rq;
      logic signed [31:0] edges[4];
      int wait_cnt;
      edges[0] = SMAX; edges[1] = SMIN; edges[2] = 0; edges[3] = 32'sh0001_0000;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      idle_cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: every action on extremes, zero vector and zero divisor
      for (int act = 0; act < 8; act++) begin
         for (int k = 0; k < 3; k++) begin
            rq.action = 3'(act);
            rq.a_x = edges[k]; rq.a_y = edges[(k + 1) % 4]; rq.a_z = edges[k];
            rq.b_x = edges[k]; rq.b_y = edges[k]; rq.b_z = edges[(k + 3) % 4];
            rq.scalar_in = (k == 2) ? 32'sd0 : edges[k];
            if (k == 2 && act == ACT_NORM) begin
               rq.a_x = 0; rq.a_y = 0; rq.a_z = 0;
            end
            send_request(rq, k);
         end
      end
      for (int n = 0; n < 450; n++) begin
         // bursts with no gaps now and then
         send_random((n % 60 < 15) ? 0 : $urandom_range(0, 19));
         if (n == 200) begin
            // hold off until the unit has drained
            start <= 1'b0;
            wait_cnt = 0;
            while (pending_count != 0 && wait_cnt < 100000) begin
               @(posedge clock);
               wait_cnt++;
            end
            @(negedge clock);
         end
      end
      start <= 1'b0;
      wait_cnt = 0;
      while (pending_count != 0 && wait_cnt < 200000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
